// ===== src/sps_pkg.sv =====
// Shared types, codes and constants for the SPI EEPROM page sequencer.
package sps_pkg;

	// Default geometry of the memory array
	localparam int unsigned SPS_PAGE_BYTES  = 64;
	localparam int unsigned SPS_PAGE_COUNT  = 512;
	localparam int unsigned SPS_QUEUE_DEPTH = 2;

	// Request kinds as they arrive on the kind port
	localparam logic [1:0] KIND_IN_READ  = 2'd0;
	localparam logic [1:0] KIND_IN_WRITE = 2'd1;
	localparam logic [1:0] KIND_IN_ERASE = 2'd2;

	// Item opcodes on the op port
	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_FRAME    = 2'd0;
	localparam logic [1:0] ST_DONE     = 2'd1;
	localparam logic [1:0] ST_REJECT   = 2'd2;
	localparam logic [1:0] ST_IDLE_ADV = 2'd3;

	// SPI command bytes
	localparam logic [7:0] OPC_READ  = 8'h03;
	localparam logic [7:0] OPC_WRITE = 8'h02;
	localparam logic [7:0] OPC_WREN  = 8'h06;

	// Classified command handed from the front end to the back end
	typedef enum logic [2:0] {
		CMD_ADVANCE,
		CMD_READ,
		CMD_WRITE,
		CMD_ERASE,
		CMD_REJECT
	} cmd_e;

	// Request held by the back end
	typedef enum logic [1:0] {
		ACT_IDLE,
		ACT_READ,
		ACT_WRITE,
		ACT_ERASE
	} active_e;

	// What the back end does with one command
	typedef enum logic [2:0] {
		STEP_REJECT,
		STEP_IDLE,
		STEP_DONE,
		STEP_ENABLE,
		STEP_PAGE
	} step_e;

	typedef struct packed {
		cmd_e        cmd;
		logic [14:0] address;
		logic [15:0] length;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  opcode;
		logic [14:0] mem_address;
		logic [14:0] buffer_offset;
		logic [6:0]  byte_count;
		logic        zero_fill;
		logic        last;
	} res_t;

endpackage

// ===== src/sps_fifo.sv =====
// Small register queue used between the sequencer stages.
module sps_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/sps_front.sv =====
// Front end: takes transactions in, checks range and classifies requests.
module sps_front #(
	parameter  int unsigned PAGE_BYTES = 64,
	parameter  int unsigned PAGE_COUNT = 512,
	localparam int unsigned OFF_W      = $clog2(PAGE_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              op,
	input  logic [1:0]        kind,
	input  logic [14:0]       address,
	input  logic [15:0]       length,
	input  logic              mid_full,
	output logic              mid_push,
	output sps_pkg::cmd_t     mid_cmd,
	output logic [OFF_W-1:0]  mid_offs
);
	import sps_pkg::*;

	localparam int unsigned TOTAL  = PAGE_BYTES * PAGE_COUNT;
	localparam int unsigned TOT_W  = $clog2(TOTAL + 1);
	localparam int unsigned CMP_W  = (TOT_W > 17) ? TOT_W : 17;
	// Reciprocal of the page size, exact for every 15-bit address
	localparam int unsigned RCP_SH = 23;
	localparam int unsigned RCP    = ((2 ** RCP_SH) + PAGE_BYTES - 1) / PAGE_BYTES;
	localparam int unsigned RCP_W  = $clog2(RCP + 1);
	localparam int unsigned PROD_W = 15 + RCP_W;
	localparam int unsigned Q_W    = PROD_W - RCP_SH;

	logic              v_s1;
	logic              op_s1;
	logic [1:0]        kind_s1;
	logic [14:0]       address_s1;
	logic [15:0]       length_s1;
	logic [Q_W-1:0]    page_s1;

	logic              advance;
	logic              accept;
	logic [PROD_W-1:0] prod;
	logic [23:0]       page_base;
	logic [23:0]       offs_full;
	logic [CMP_W-1:0]  end_addr;
	logic              in_range;

	assign full    = v_s1 && mid_full;
	assign advance = !v_s1 || !mid_full;
	assign accept  = push && !full;
	assign prod    = PROD_W'(address) * PROD_W'(RCP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op;
			kind_s1    <= kind;
			address_s1 <= address;
			length_s1  <= length;
			page_s1    <= prod[PROD_W-1:RCP_SH];
		end
	end

	// Offset within the page from the registered page number
	assign page_base = 24'(page_s1) * 24'(PAGE_BYTES);
	assign offs_full = 24'(address_s1) - page_base;
	assign mid_offs  = offs_full[OFF_W-1:0];

	assign end_addr  = CMP_W'(address_s1) + CMP_W'(length_s1);
	assign in_range  = (end_addr <= CMP_W'(TOTAL));
	assign mid_push  = v_s1 && !mid_full;

	always_comb begin
		mid_cmd.address = address_s1;
		mid_cmd.length  = length_s1;
		if (op_s1 == OP_ADVANCE) begin
			mid_cmd.cmd = CMD_ADVANCE;
		end else begin
			unique case (kind_s1)
				KIND_IN_ERASE: mid_cmd.cmd = CMD_ERASE;
				KIND_IN_READ:  mid_cmd.cmd = in_range ? CMD_READ : CMD_REJECT;
				KIND_IN_WRITE: mid_cmd.cmd = in_range ? CMD_WRITE : CMD_REJECT;
				default:       mid_cmd.cmd = CMD_REJECT;
			endcase
		end
	end

endmodule

// ===== src/sps_back.sv =====
// Back end: holds the running request and issues one frame descriptor per command.
module sps_back #(
	parameter  int unsigned PAGE_BYTES = 64,
	parameter  int unsigned PAGE_COUNT = 512,
	localparam int unsigned OFF_W      = $clog2(PAGE_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mid_valid,
	input  sps_pkg::cmd_t     mid_cmd,
	input  logic [OFF_W-1:0]  mid_offs,
	output logic              mid_pop,
	input  logic              res_full,
	output logic              res_push,
	output sps_pkg::res_t     res
);
	import sps_pkg::*;

	localparam int unsigned TOTAL = PAGE_BYTES * PAGE_COUNT;
	localparam int unsigned TOT_W = $clog2(TOTAL + 1);
	localparam int unsigned NA_W  = (TOT_W > 15) ? TOT_W : 15;
	localparam int unsigned BL_W  = (TOT_W > 16) ? TOT_W : 16;
	localparam int unsigned CH_W  = $clog2(PAGE_BYTES + 1);

	active_e          kind_q;
	logic [NA_W-1:0]  na_q;
	logic [BL_W-1:0]  bl_q;
	logic [15:0]      bp_q;
	logic             ep_q;
	logic [OFF_W-1:0] off_q;

	active_e          eff_kind;
	logic [NA_W-1:0]  eff_na;
	logic [BL_W-1:0]  eff_bl;
	logic [15:0]      eff_bp;
	logic             eff_ep;
	logic [OFF_W-1:0] eff_off;

	active_e          kind_d;
	logic [NA_W-1:0]  na_d;
	logic [BL_W-1:0]  bl_d;
	logic [15:0]      bp_d;
	logic             ep_d;
	logic [OFF_W-1:0] off_d;

	step_e            step;
	logic             fire;
	logic             erase;
	logic [CH_W-1:0]  room;
	logic [CH_W-1:0]  chunk;
	logic [CH_W-1:0]  off_sum;
	logic [OFF_W-1:0] off_next;
	logic [NA_W-1:0]  na_sum;
	logic [BL_W-1:0]  bl_diff;
	logic [15:0]      bp_sum;

	assign fire     = mid_valid && !res_full;
	assign mid_pop  = fire;
	assign res_push = fire;

	// A start loads the request, then issues its first frame in the same step
	always_comb begin
		eff_kind = kind_q;
		eff_na   = na_q;
		eff_bl   = bl_q;
		eff_bp   = bp_q;
		eff_ep   = ep_q;
		eff_off  = off_q;
		unique case (mid_cmd.cmd)
			CMD_READ, CMD_WRITE: begin
				eff_kind = (mid_cmd.cmd == CMD_READ) ? ACT_READ : ACT_WRITE;
				eff_na   = NA_W'(mid_cmd.address);
				eff_bl   = BL_W'(mid_cmd.length);
				eff_bp   = '0;
				eff_ep   = 1'b0;
				eff_off  = mid_offs;
			end
			CMD_ERASE: begin
				eff_kind = ACT_ERASE;
				eff_na   = '0;
				eff_bl   = BL_W'(TOTAL);
				eff_bp   = '0;
				eff_ep   = 1'b0;
				eff_off  = '0;
			end
			CMD_REJECT: begin
				eff_kind = ACT_IDLE;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (mid_cmd.cmd == CMD_REJECT) begin
			step = STEP_REJECT;
		end else if (eff_kind == ACT_IDLE) begin
			step = STEP_IDLE;
		end else if (eff_bl == '0) begin
			step = STEP_DONE;
		end else if (eff_kind != ACT_READ && !eff_ep) begin
			step = STEP_ENABLE;
		end else begin
			step = STEP_PAGE;
		end
	end

	// Page frame: stop at the page boundary or the end of the request
	assign erase    = (eff_kind == ACT_ERASE);
	assign room     = CH_W'(PAGE_BYTES) - CH_W'(eff_off);
	assign chunk    = (eff_bl < BL_W'(room)) ? CH_W'(eff_bl) : room;
	assign off_sum  = CH_W'(eff_off) + chunk;
	assign off_next = (off_sum == CH_W'(PAGE_BYTES)) ? '0 : OFF_W'(off_sum);
	assign na_sum   = eff_na + NA_W'(chunk);
	assign bl_diff  = eff_bl - BL_W'(chunk);
	assign bp_sum   = eff_bp + 16'(chunk);

	// Next state
	always_comb begin
		kind_d = kind_q;
		na_d   = na_q;
		bl_d   = bl_q;
		bp_d   = bp_q;
		ep_d   = ep_q;
		off_d  = off_q;
		unique case (step)
			STEP_REJECT, STEP_DONE: begin
				kind_d = ACT_IDLE;
				na_d   = '0;
				bl_d   = '0;
				bp_d   = '0;
				ep_d   = 1'b0;
				off_d  = '0;
			end
			STEP_ENABLE: begin
				kind_d = eff_kind;
				na_d   = eff_na;
				bl_d   = eff_bl;
				bp_d   = eff_bp;
				ep_d   = 1'b1;
				off_d  = eff_off;
			end
			STEP_PAGE: begin
				kind_d = eff_kind;
				na_d   = na_sum;
				bl_d   = bl_diff;
				bp_d   = erase ? eff_bp : bp_sum;
				ep_d   = 1'b0;
				off_d  = off_next;
			end
			default: begin
			end
		endcase
	end

	// Result fields
	always_comb begin
		res = '0;
		unique case (step)
			STEP_REJECT: res.status = ST_REJECT;
			STEP_IDLE:   res.status = ST_IDLE_ADV;
			STEP_DONE:   res.status = ST_DONE;
			STEP_ENABLE: begin
				res.status        = ST_FRAME;
				res.opcode        = OPC_WREN;
				res.mem_address   = eff_na[14:0];
				res.buffer_offset = erase ? '0 : eff_bp[14:0];
			end
			STEP_PAGE: begin
				res.status        = ST_FRAME;
				res.opcode        = (eff_kind == ACT_READ) ? OPC_READ : OPC_WRITE;
				res.mem_address   = eff_na[14:0];
				res.buffer_offset = erase ? '0 : eff_bp[14:0];
				res.byte_count    = 7'(chunk);
				res.zero_fill     = erase;
				res.last          = (bl_diff == '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= ACT_IDLE;
			na_q   <= '0;
			bl_q   <= '0;
			bp_q   <= '0;
			ep_q   <= 1'b0;
			off_q  <= '0;
		end else if (fire) begin
			kind_q <= kind_d;
			na_q   <= na_d;
			bl_q   <= bl_d;
			bp_q   <= bp_d;
			ep_q   <= ep_d;
			off_q  <= off_d;
		end
	end

endmodule

// ===== src/spi_eeprom_page_sequencer.sv =====
// Top level of the SPI EEPROM page sequencer: front end, command queue, back end, result queue.
// Each transaction on the input side gives exactly one result transaction: a start item
// (op 0) takes a read, write or whole-array erase and answers with its first frame
// descriptor (or done for a zero-length transfer, or rejected when address plus length
// passes the end of the array or the kind is unknown); an advance item (op 1) answers with
// the next descriptor, done after the last frame, or idle when no request runs. Transfers
// split at page boundaries, and every write or erase page frame is preceded by a
// write-enable frame. The block takes one transaction per clock cycle while full is low; a
// result passes the front stage register (which works out the in-page offset with a
// reciprocal multiply and checks the range), then the command queue, and then the back end,
// which updates the request registers and builds the descriptor in the cycle it takes a
// command, writing it straight into the result queue. Both queues hold two entries, so either
// side may stall without stopping the other at once; full rises only when the command queue
// and the front stage are both taken.
module spi_eeprom_page_sequencer #(
	parameter int unsigned PAGE_BYTES = sps_pkg::SPS_PAGE_BYTES,
	parameter int unsigned PAGE_COUNT = sps_pkg::SPS_PAGE_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [1:0]  kind,
	input  logic [14:0] address,
	input  logic [15:0] length,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [7:0]  opcode,
	output logic [14:0] mem_address,
	output logic [14:0] buffer_offset,
	output logic [6:0]  byte_count,
	output logic        zero_fill,
	output logic        last
);
	import sps_pkg::*;

	localparam int unsigned OFF_W   = $clog2(PAGE_BYTES);
	localparam int unsigned CMD_W   = $bits(cmd_t) + OFF_W;
	localparam int unsigned RES_W   = $bits(res_t);

	// Front end to command queue
	logic             front_push;
	cmd_t             front_cmd;
	logic [OFF_W-1:0] front_offs;
	logic             mid_full;

	// Command queue to back end
	logic [CMD_W-1:0] mid_dout;
	logic             mid_empty;
	logic             mid_pop;
	cmd_t             mid_cmd;
	logic [OFF_W-1:0] mid_offs;

	// Back end to result queue
	logic             res_push;
	logic             res_full;
	res_t             back_res;
	logic [RES_W-1:0] res_dout;
	res_t             head;

	sps_front #(
		.PAGE_BYTES (PAGE_BYTES),
		.PAGE_COUNT (PAGE_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.op       (op),
		.kind     (kind),
		.address  (address),
		.length   (length),
		.mid_full (mid_full),
		.mid_push (front_push),
		.mid_cmd  (front_cmd),
		.mid_offs (front_offs)
	);

	// Classified commands wait here until the back end takes them
	sps_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (SPS_QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.din    ({front_cmd, front_offs}),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_dout),
		.empty  (mid_empty)
	);

	assign mid_cmd  = cmd_t'(mid_dout[CMD_W-1:OFF_W]);
	assign mid_offs = mid_dout[OFF_W-1:0];

	sps_back #(
		.PAGE_BYTES (PAGE_BYTES),
		.PAGE_COUNT (PAGE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_valid (!mid_empty),
		.mid_cmd   (mid_cmd),
		.mid_offs  (mid_offs),
		.mid_pop   (mid_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	// Finished descriptors wait here for the consumer
	sps_fifo #(
		.WIDTH (RES_W),
		.DEPTH (SPS_QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (back_res),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_dout),
		.empty  (empty)
	);

	// Present the oldest waiting result
	assign head          = res_t'(res_dout);
	assign status        = head.status;
	assign opcode        = head.opcode;
	assign mem_address   = head.mem_address;
	assign buffer_offset = head.buffer_offset;
	assign byte_count    = head.byte_count;
	assign zero_fill     = head.zero_fill;
	assign last          = head.last;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the SPI EEPROM page sequencer: random requests checked by a frame predictor.
module tb_top;
	import sps_pkg::*;

	localparam int unsigned ARRAY_BYTES = SPS_PAGE_BYTES * SPS_PAGE_COUNT;
	localparam int unsigned STALL_LIMIT = 400;	// cycles with no transaction before giving up
	localparam int unsigned HOLD_CYCLES = 64;	// long receiver hold-off, well past both queues
	localparam int unsigned ITEM_BUDGET = 1800;
	localparam int unsigned SETTLE      = 8;	// allow margin for results still in flight
	localparam logic [1:0]  KIND_IN_BAD = 2'd3;	// the one kind code the block must refuse

	// Shadow of the sequencer: the same request registers, advanced once per accepted
	// transaction, and a queue of the frame descriptors the block owes us.
	class frame_tracker;
		active_e     act;
		int unsigned cur_addr;
		int unsigned left;
		int unsigned buf_pos;
		bit          wren_sent;
		res_t        due_frames[$];
		int unsigned faults = 0;
		int unsigned by_status[4] = '{0, 0, 0, 0};
		int unsigned wren_frames = 0;
		int unsigned last_frames = 0;

		function new();
			go_idle();
		endfunction

		function void go_idle();
			act       = ACT_IDLE;
			cur_addr  = 0;
			left      = 0;
			buf_pos   = 0;
			wren_sent = 1'b0;
		endfunction

		function bit busy();
			return act != ACT_IDLE;
		endfunction

		function int unsigned pending();
			return due_frames.size();
		endfunction

		// Build a descriptor, masking each field to its port width.
		function res_t descriptor(logic [1:0] st, logic [7:0] opc, int unsigned addr,
				int unsigned boff, int unsigned cnt, bit zf, bit lst);
			res_t r;
			r.status        = st;
			r.opcode        = opc;
			r.mem_address   = addr[14:0];
			r.buffer_offset = boff[14:0];
			r.byte_count    = cnt[6:0];
			r.zero_fill     = zf;
			r.last          = lst;
			return r;
		endfunction

		// Next frame of the running request: done once nothing is left, a write-enable
		// ahead of every write or erase page, otherwise the page up to its boundary or the request end.
		function res_t issue_next();
			int unsigned chunk;
			int unsigned addr;
			int unsigned boff;
			bit          erasing;
			if (left == 0) begin
				go_idle();
				return descriptor(ST_DONE, '0, 0, 0, 0, 1'b0, 1'b0);
			end
			erasing = (act == ACT_ERASE);
			boff    = erasing ? 0 : buf_pos;
			if (act != ACT_READ && !wren_sent) begin
				wren_sent = 1'b1;
				return descriptor(ST_FRAME, OPC_WREN, cur_addr, boff, 0, 1'b0, 1'b0);
			end
			wren_sent = 1'b0;
			chunk     = SPS_PAGE_BYTES - (cur_addr % SPS_PAGE_BYTES);
			if (left < chunk)
				chunk = left;
			addr      = cur_addr;
			cur_addr += chunk;
			left     -= chunk;
			if (!erasing)
				buf_pos += chunk;
			return descriptor(ST_FRAME, (act == ACT_READ) ? OPC_READ : OPC_WRITE,
				addr, boff, chunk, erasing, left == 0);
		endfunction

		// Note one accepted input transaction and queue the result it must cause.
		function void note_item(logic o, logic [1:0] k, logic [14:0] a, logic [15:0] l);
			int unsigned span;
			res_t        r;
			span = a;
			span = span + l;
			if (o == OP_ADVANCE) begin
				if (busy())
					r = issue_next();
				else
					r = descriptor(ST_IDLE_ADV, '0, 0, 0, 0, 1'b0, 1'b0);
			end else begin
				// any start drops whatever was running
				go_idle();
				if (k == KIND_IN_ERASE) begin
					act  = ACT_ERASE;
					left = ARRAY_BYTES;
					r    = issue_next();
				end else if ((k == KIND_IN_READ || k == KIND_IN_WRITE) && span <= ARRAY_BYTES) begin
					act      = (k == KIND_IN_READ) ? ACT_READ : ACT_WRITE;
					cur_addr = a;
					left     = l;
					r        = issue_next();
				end else begin
					r = descriptor(ST_REJECT, '0, 0, 0, 0, 1'b0, 1'b0);
				end
			end
			due_frames.push_back(r);
		endfunction

		function string show(res_t r);
			return $sformatf("status %0d opcode %02h addr %0d boff %0d count %0d zero %0b last %0b",
				r.status, r.opcode, r.mem_address, r.buffer_offset, r.byte_count,
				r.zero_fill, r.last);
		endfunction

		// Compare one accepted result with the oldest outstanding descriptor.
		function void check_frame(res_t got);
			res_t want;
			if (due_frames.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("result with nothing outstanding: %s", show(got));
				return;
			end
			want = due_frames.pop_front();
			by_status[want.status]++;
			if (want.status == ST_FRAME && want.opcode == OPC_WREN)
				wren_frames++;
			if (want.last)
				last_frames++;
			if (got !== want) begin
				faults++;
				if (faults <= 10)
					$display("descriptor mismatch\n  expected %s\n  actual   %s",
						show(want), show(got));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        op;
	logic [1:0]  kind;
	logic [14:0] address;
	logic [15:0] length;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic [7:0]  opcode;
	logic [14:0] mem_address;
	logic [14:0] buffer_offset;
	logic [6:0]  byte_count;
	logic        zero_fill;
	logic        last;

	frame_tracker book;
	int unsigned  items_sent = 0;
	int unsigned  tx_gap_max = 7;
	int unsigned  rx_gap_max = 7;
	bit           rx_hold_req = 1'b0;
	int unsigned  full_cycles = 0;
	bit           full_erase_done = 1'b0;

	spi_eeprom_page_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.op            (op),
		.kind          (kind),
		.address       (address),
		.length        (length),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.opcode        (opcode),
		.mem_address   (mem_address),
		.buffer_offset (buffer_offset),
		.byte_count    (byte_count),
		.zero_fill     (zero_fill),
		.last          (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one item and hold it until the block takes it, then idle for a drawn gap.
	// Push stays high across back-to-back items so it is never dropped and raised in one step.
	task automatic send_item(input logic o, input logic [1:0] k, input logic [14:0] a,
			input logic [15:0] l);
		int unsigned gap;
		push    <= 1'b1;
		op      <= o;
		kind    <= k;
		address <= a;
		length  <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
		book.note_item(o, k, a, l);
		items_sent++;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Advance with random content on the fields the block ignores for it.
	task automatic advance();
		logic [1:0]  k;
		logic [14:0] a;
		logic [15:0] l;
		k = 2'($urandom);
		a = 15'($urandom);
		l = 16'($urandom);
		send_item(OP_ADVANCE, k, a, l);
	endtask

	task automatic run_to_end();
		while (book.busy())
			advance();
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic wait_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (book.pending() != 0);
	endtask

	// Draw an in-range span: mostly a few pages, sometimes many, now and then empty.
	task automatic pick_span(output logic [14:0] a, output logic [15:0] l);
		int unsigned r;
		int unsigned n;
		int unsigned base;
		r = $urandom_range(0, 19);
		if (r < 14)
			n = $urandom_range(1, 200);
		else if (r < 19)
			n = $urandom_range(200, 1500);
		else
			n = 0;
		base = $urandom_range(0, ARRAY_BYTES - 1);
		if (base + n > ARRAY_BYTES)
			base = ARRAY_BYTES - n;
		a = 15'(base);
		l = 16'(n);
	endtask

	// Receiver: pop with drawn stalls, one long hold-off on request, check every result.
	initial begin
		int unsigned stall;
		int unsigned rx_count;
		res_t        got;
		rx_count = 0;
		pop = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = $urandom_range(0, rx_gap_max);
			end
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			got.status        = status;
			got.opcode        = opcode;
			got.mem_address   = mem_address;
			got.buffer_offset = buffer_offset;
			got.byte_count    = byte_count;
			got.zero_fill     = zero_fill;
			got.last          = last;
			book.check_frame(got);
			rx_count++;
			// every forty results, draw again between eager and lazy popping
			if (rx_count % 40 == 0)
				rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
		end
	end

	// Watchdog: end the run if no transaction moves on either side for too long.
	initial begin
		int unsigned idle_run;
		idle_run = 0;
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if (push && full)
				full_cycles++;
			if (!arst_n || (push && !full) || (pop && !empty))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("no transaction for %0d cycles, %0d results outstanding",
			STALL_LIMIT, book.pending());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned pick;
		int unsigned n;
		int unsigned d;
		logic [1:0]  k;
		logic [14:0] a;
		logic [15:0] l;
		bit          burst_done;
		bit          drain_done;
		book       = new();
		burst_done = 1'b0;
		drain_done = 1'b0;
		push       = 1'b0;
		op         = OP_START;
		kind       = KIND_IN_READ;
		address    = '0;
		length     = '0;
		arst_n     = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: corner cases of the request set
		advance();						// advance with nothing running
		send_item(OP_START, KIND_IN_READ, 15'd0, 16'd0);	// empty read: done at once
		send_item(OP_START, KIND_IN_WRITE, 15'd32767, 16'd1);	// last byte of the array
		advance();
		advance();						// done
		advance();						// idle again
		send_item(OP_START, KIND_IN_READ, 15'd60, 16'd10);	// straddles a page boundary
		advance();
		advance();
		send_item(OP_START, KIND_IN_READ, 15'd32767, 16'd2);	// one past the end
		send_item(OP_START, KIND_IN_WRITE, 15'd0, 16'd32768);	// exactly the whole array
		advance();
		send_item(OP_START, KIND_IN_BAD, 15'h7FFF, 16'hFFFF);	// unknown kind drops the write
		advance();
		send_item(OP_START, KIND_IN_ERASE, 15'h7FFF, 16'hFFFF);	// erase ignores span
		advance();
		advance();
		send_item(OP_START, KIND_IN_READ, 15'd1, 16'd32768);
		send_item(OP_START, KIND_IN_READ, 15'd0, 16'hFFFF);
		send_item(OP_START, KIND_IN_WRITE, 15'd5, 16'd0);

		// Random part: mostly complete requests, with abandoned ones, edge spans and noise
		while (items_sent < ITEM_BUDGET) begin
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			if (!burst_done && items_sent >= 300) begin
				// hold the receiver off and keep pushing so both queues fill and full rises
				burst_done  = 1'b1;
				rx_hold_req = 1'b1;
				tx_gap_max  = 0;
				send_item(OP_START, KIND_IN_WRITE, 15'd0, 16'd4000);
				repeat (24) advance();
			end else if (!full_erase_done && items_sent >= 800) begin
				full_erase_done = 1'b1;
				a = 15'($urandom);
				l = 16'($urandom);
				send_item(OP_START, KIND_IN_ERASE, a, l);
				run_to_end();
			end else if (!drain_done && items_sent >= 600) begin
				// let every outstanding result come back before going on
				drain_done = 1'b1;
				wait_drained();
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					pick_span(a, l);
					k = ($urandom_range(0, 1) == 0) ? KIND_IN_READ : KIND_IN_WRITE;
					send_item(OP_START, k, a, l);
					run_to_end();
					if ($urandom_range(0, 9) == 0)
						advance();
				end else if (pick < 60) begin
					// started and then abandoned by the next start
					pick_span(a, l);
					d = $urandom_range(0, 2);
					k = (d == 0) ? KIND_IN_READ : (d == 1) ? KIND_IN_WRITE : KIND_IN_ERASE;
					send_item(OP_START, k, a, l);
					repeat ($urandom_range(0, 6)) advance();
				end else if (pick < 70) begin
					// span ending one short of, exactly at, or one past the array end
					n = $urandom_range(2, 300);
					d = $urandom_range(0, 2);
					a = 15'(ARRAY_BYTES - n + d - 1);
					l = 16'(n);
					k = ($urandom_range(0, 1) == 0) ? KIND_IN_READ : KIND_IN_WRITE;
					send_item(OP_START, k, a, l);
					run_to_end();
				end else if (pick < 85) begin
					repeat (4) begin
						k = 2'($urandom);
						a = 15'($urandom);
						l = 16'($urandom);
						send_item(($urandom_range(0, 1) == 0) ? OP_START : OP_ADVANCE,
							k, a, l);
					end
				end else if (pick < 95) begin
					a = 15'($urandom);
					if ($urandom_range(0, 1) == 0) begin
						l = 16'($urandom);
						send_item(OP_START, KIND_IN_BAD, a, l);
					end else begin
						l = 16'($urandom_range(32769, 65535));
						k = ($urandom_range(0, 1) == 0) ? KIND_IN_READ : KIND_IN_WRITE;
						send_item(OP_START, k, a, l);
					end
				end else begin
					advance();
					if ($urandom_range(0, 2) == 0)
						wait_drained();
				end
			end
		end

		// Drain: stop offering, collect the rest, then allow for stray results
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("%0d transactions: %0d frames (%0d write-enable, %0d last),",
			items_sent, book.by_status[ST_FRAME], book.wren_frames, book.last_frames);
		$display("  %0d done, %0d rejected, %0d idle",
			book.by_status[ST_DONE], book.by_status[ST_REJECT], book.by_status[ST_IDLE_ADV]);
		$display("whole-array erase completed: %0b, cycles held off by full: %0d, faults: %0d",
			full_erase_done, full_cycles, book.faults);
		if (book.faults == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sps_pkg.sv
src/sps_fifo.sv
src/sps_front.sv
src/sps_back.sv
src/spi_eeprom_page_sequencer.sv
bench/tb_top.sv
